// File: design/cexl_pkg.sv
// cexl_pkg: shared types and constants of the C-style expression lexer.
// Token word layout, token kind codes and the length and position caps.
// No dependencies.
`default_nettype none

package cexl_pkg;

  // Size limits of the lexer
  localparam int MAX_TOKEN_LENGTH = 255;
  localparam int MAX_TEXT_LENGTH  = 4096;

  // Saturation points of token length and byte position
  localparam logic [7:0]  LEN_CAP =
    8'((MAX_TOKEN_LENGTH < 255) ? MAX_TOKEN_LENGTH : 255);
  localparam logic [11:0] POS_CAP =
    12'((MAX_TEXT_LENGTH - 1 < 4095) ? (MAX_TEXT_LENGTH - 1) : 4095);

  // Token kind codes
  localparam logic [2:0] KIND_PAREN  = 3'd0;
  localparam logic [2:0] KIND_STRING = 3'd1;
  localparam logic [2:0] KIND_NUMBER = 3'd2;
  localparam logic [2:0] KIND_UNARY  = 3'd3;
  localparam logic [2:0] KIND_WORD   = 3'd4;
  localparam logic [2:0] KIND_END    = 3'd5;

  // One token word
  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] start;
    logic [7:0]  length;
    logic        clipped;
    logic        last;
  } tok_t;

  // Tokens produced by one text byte, in order
  typedef struct packed {
    tok_t [2:0] tok;
    logic [1:0] count;
  } scan_out_t;

endpackage

`default_nettype wire

// File: design/cexl_scan.sv
// cexl_scan: lexer state and the per-byte next-state and token logic.
// Produces up to three token words for each accepted text byte.
// Depends on cexl_pkg.
`default_nettype none

module cexl_scan #(
  parameter int MAX_TOKEN_LENGTH = cexl_pkg::MAX_TOKEN_LENGTH,
  parameter int MAX_TEXT_LENGTH  = cexl_pkg::MAX_TEXT_LENGTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            character,
  input  logic                  end_of_text,
  output cexl_pkg::scan_out_t   scan_out
);

  // Saturation points of token length and byte position
  localparam logic [7:0]  LEN_CAP =
    8'((MAX_TOKEN_LENGTH < 255) ? MAX_TOKEN_LENGTH : 255);
  localparam logic [11:0] POS_CAP =
    12'((MAX_TEXT_LENGTH - 1 < 4095) ? (MAX_TEXT_LENGTH - 1) : 4095);

  typedef enum logic [10:0] {
    M_IDLE    = 11'b000_0000_0001,
    M_STRING  = 11'b000_0000_0010,
    M_ZERO    = 11'b000_0000_0100,
    M_DEC     = 11'b000_0000_1000,
    M_EXPSIGN = 11'b000_0001_0000,
    M_HEX     = 11'b000_0010_0000,
    M_BIN     = 11'b000_0100_0000,
    M_INTSUF  = 11'b000_1000_0000,
    M_IDENT   = 11'b001_0000_0000,
    M_OPPEND  = 11'b010_0000_0000,
    M_DOTPEND = 11'b100_0000_0000
  } mode_t;

  typedef enum logic [1:0] {
    P_NONE  = 2'd0,
    P_NUM   = 2'd1,
    P_CLOSE = 2'd2,
    P_OTHER = 2'd3
  } prev_t;

  // Per-token scan context
  typedef struct packed {
    mode_t      mode;
    logic [7:0] held;
    logic [7:0] len;
    logic       over;
    logic       dot;
    logic       expo;
    logic [7:0] quote;
    logic       esc;
  } run_t;

  localparam run_t RUN_IDLE = '{M_IDLE, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0};

  // Character classes
  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {" ", [8'd9:8'd13]};
  endfunction

  function automatic logic is_lsuffix(input logic [7:0] c);
    return c inside {"u", "U", "l", "L"};
  endfunction

  function automatic logic opens_pair(input logic [7:0] c);
    return c inside {"=", "!", "<", ">", "&", "|", "-", "+", "*", "/", "%", "^"};
  endfunction

  function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
    return (b == "=") || ((b == ">") && ((a == "-") || (a == ">"))) ||
           ((a == b) && (a inside {"&", "|", "<"}));
  endfunction

  // One-byte token kind: paren for ( and ), unary for + - * & = unless after a number or closing paren, else word
  function automatic logic [2:0] single_kind(input logic [7:0] c, input prev_t p);
    logic [2:0] k;
    k = cexl_pkg::KIND_WORD;
    if ((c == "(") || (c == ")")) begin
      k = cexl_pkg::KIND_PAREN;
    end else if (c inside {"+", "-", "*", "&", "="}) begin
      k = ((p == P_NUM) || (p == P_CLOSE)) ? cexl_pkg::KIND_WORD : cexl_pkg::KIND_UNARY;
    end
    return k;
  endfunction

  function automatic prev_t single_prev(input logic [7:0] c);
    return (c == ")") ? P_CLOSE : P_OTHER;
  endfunction

  // Saturating length step: returns {over, len}
  function automatic logic [8:0] grown(input logic [7:0] l, input logic o);
    logic [8:0] r;
    if (l >= LEN_CAP) r = {1'b1, l};
    else r = {o, l + 8'd1};
    return r;
  endfunction

  function automatic cexl_pkg::tok_t mk(input logic [2:0] k, input logic [11:0] s,
                                        input logic [7:0] l, input logic o,
                                        input logic e);
    cexl_pkg::tok_t t;
    t.kind    = k;
    t.start   = s;
    t.length  = l;
    t.clipped = o;
    t.last    = e;
    return t;
  endfunction

  // State registers
  run_t        run;
  prev_t       prev_kind;
  logic [11:0] start_pos;
  logic [11:0] byte_pos;

  run_t        run_next;
  prev_t       prev_next;
  logic [11:0] start_next;
  logic [11:0] pos_next;

  // Candidate words: scan, begin, flush, end marker
  cexl_pkg::tok_t [3:0] cand;
  logic [3:0]           cand_v;
  logic                 go_dec;
  logic                 go_suf;
  logic                 go_begin;
  logic [7:0]           held_c;
  logic [2:0]           n;

  // Per-byte lexer step
  always_comb begin
    run_next   = run;
    prev_next  = prev_kind;
    start_next = start_pos;
    cand       = '0;
    cand_v     = '0;
    go_dec     = 1'b0;
    go_suf     = 1'b0;
    go_begin   = 1'b0;
    held_c     = run.held;

    // continue the open token
    case (run.mode)
      M_STRING: begin
        {run_next.over, run_next.len} = grown(run_next.len, run_next.over);
        if (run.esc) begin
          run_next.esc = 1'b0;
        end else if (character == "\\") begin
          run_next.esc = 1'b1;
        end else if (character == run.quote) begin
          cand[0]   = mk(cexl_pkg::KIND_STRING, start_pos, run_next.len, run_next.over, 1'b0);
          cand_v[0] = 1'b1;
          prev_next = P_OTHER;
          run_next  = RUN_IDLE;
        end
      end
      M_ZERO: begin
        if ((character == "x") || (character == "X")) begin
          {run_next.over, run_next.len} = grown(run_next.len, run_next.over);
          run_next.mode = M_HEX;
        end else if ((character == "b") || (character == "B")) begin
          {run_next.over, run_next.len} = grown(run_next.len, run_next.over);
          run_next.mode = M_BIN;
        end else begin
          go_dec = 1'b1;
        end
      end
      M_DEC: go_dec = 1'b1;
      M_EXPSIGN: begin
        if ((character == "+") || (character == "-")) begin
          {run_next.over, run_next.len} = grown(run_next.len, run_next.over);
          run_next.mode = M_DEC;
        end else begin
          go_dec = 1'b1;
        end
      end
      M_HEX: begin
        if (is_xdigit(character)) begin
          {run_next.over, run_next.len} = grown(run_next.len, run_next.over);
        end else begin
          go_suf = 1'b1;
        end
      end
      M_BIN: begin
        if ((character == "0") || (character == "1")) begin
          {run_next.over, run_next.len} = grown(run_next.len, run_next.over);
        end else begin
          go_suf = 1'b1;
        end
      end
      M_INTSUF: go_suf = 1'b1;
      M_IDENT: begin
        if (is_alpha(character) || is_digit(character) || (character == "_")) begin
          {run_next.over, run_next.len} = grown(run_next.len, run_next.over);
        end else begin
          cand[0]   = mk(cexl_pkg::KIND_WORD, start_pos, run.len, run.over, 1'b0);
          cand_v[0] = 1'b1;
          prev_next = P_OTHER;
          run_next  = RUN_IDLE;
          go_begin  = 1'b1;
        end
      end
      M_OPPEND: begin
        run_next = RUN_IDLE;
        if (is_pair(held_c, character)) begin
          cand[0]   = mk(cexl_pkg::KIND_WORD, start_pos, 8'd2, 1'b0, 1'b0);
          cand_v[0] = 1'b1;
          prev_next = P_OTHER;
        end else begin
          cand[0]   = mk(single_kind(held_c, prev_kind), start_pos, 8'd1, 1'b0, 1'b0);
          cand_v[0] = 1'b1;
          prev_next = single_prev(held_c);
          go_begin  = 1'b1;
        end
      end
      M_DOTPEND: begin
        if (is_digit(character)) begin
          run_next.held = 8'd0;
          run_next.dot  = 1'b1;
          run_next.expo = 1'b0;
          {run_next.over, run_next.len} = grown(run_next.len, run_next.over);
          run_next.mode = M_DEC;
        end else begin
          run_next  = RUN_IDLE;
          cand[0]   = mk(single_kind(".", prev_kind), start_pos, 8'd1, 1'b0, 1'b0);
          cand_v[0] = 1'b1;
          prev_next = single_prev(".");
          go_begin  = 1'b1;
        end
      end
      default: begin
        run_next = RUN_IDLE;
        go_begin = 1'b1;
      end
    endcase

    // decimal and float body
    if (go_dec) begin
      run_next.mode = M_DEC;
      if (is_digit(character)) begin
        {run_next.over, run_next.len} = grown(run_next.len, run_next.over);
      end else if ((character == ".") && !run_next.dot) begin
        run_next.dot = 1'b1;
        {run_next.over, run_next.len} = grown(run_next.len, run_next.over);
      end else if (((character == "e") || (character == "E")) && !run_next.expo) begin
        run_next.expo = 1'b1;
        {run_next.over, run_next.len} = grown(run_next.len, run_next.over);
        run_next.mode = M_EXPSIGN;
      end else if (character inside {"f", "F", "l", "L"}) begin
        {run_next.over, run_next.len} = grown(run_next.len, run_next.over);
        run_next.mode = M_INTSUF;
      end else begin
        go_suf = 1'b1;
      end
    end

    // integer suffix run, or the number ends here
    if (go_suf) begin
      if (is_lsuffix(character)) begin
        {run_next.over, run_next.len} = grown(run_next.len, run_next.over);
        run_next.mode = M_INTSUF;
      end else begin
        cand[0]   = mk(cexl_pkg::KIND_NUMBER, start_pos, run_next.len, run_next.over, 1'b0);
        cand_v[0] = 1'b1;
        prev_next = P_NUM;
        run_next  = RUN_IDLE;
        go_begin  = 1'b1;
      end
    end

    // start a new token at this byte
    if (go_begin && !is_space(character)) begin
      if ((character == "\"") || (character == "'")) begin
        run_next.mode  = M_STRING;
        start_next     = byte_pos;
        run_next.len   = 8'd1;
        run_next.over  = 1'b0;
        run_next.quote = character;
        run_next.esc   = 1'b0;
      end else if (is_digit(character)) begin
        run_next.mode = (character == "0") ? M_ZERO : M_DEC;
        start_next    = byte_pos;
        run_next.len  = 8'd1;
        run_next.over = 1'b0;
        run_next.dot  = 1'b0;
        run_next.expo = 1'b0;
      end else if (character == ".") begin
        run_next.mode = M_DOTPEND;
        start_next    = byte_pos;
        run_next.len  = 8'd1;
        run_next.over = 1'b0;
        run_next.held = character;
      end else if (is_alpha(character) || (character == "_")) begin
        run_next.mode = M_IDENT;
        start_next    = byte_pos;
        run_next.len  = 8'd1;
        run_next.over = 1'b0;
      end else if (opens_pair(character)) begin
        run_next.mode = M_OPPEND;
        start_next    = byte_pos;
        run_next.len  = 8'd1;
        run_next.over = 1'b0;
        run_next.held = character;
      end else begin
        cand[1]   = mk(single_kind(character, prev_next), byte_pos, 8'd1, 1'b0, 1'b0);
        cand_v[1] = 1'b1;
        prev_next = single_prev(character);
      end
    end

    pos_next = (byte_pos < POS_CAP) ? byte_pos + 12'd1 : byte_pos;

    // end of text: flush the open token, then the end marker
    if (end_of_text) begin
      if (run_next.mode inside {M_STRING, M_IDENT}) begin
        cand[2]   = mk(cexl_pkg::KIND_WORD, start_next, run_next.len, run_next.over, 1'b0);
        cand_v[2] = 1'b1;
      end else if (run_next.mode inside {M_ZERO, M_DEC, M_EXPSIGN, M_HEX, M_BIN,
                                         M_INTSUF}) begin
        cand[2]   = mk(cexl_pkg::KIND_NUMBER, start_next, run_next.len, run_next.over, 1'b0);
        cand_v[2] = 1'b1;
      end else if (run_next.mode == M_OPPEND) begin
        cand[2]   = mk(single_kind(run_next.held, prev_next), start_next, 8'd1, 1'b0, 1'b0);
        cand_v[2] = 1'b1;
      end else if (run_next.mode == M_DOTPEND) begin
        cand[2]   = mk(single_kind(".", prev_next), start_next, 8'd1, 1'b0, 1'b0);
        cand_v[2] = 1'b1;
      end
      cand[3]    = mk(cexl_pkg::KIND_END, pos_next, 8'd0, 1'b0, 1'b1);
      cand_v[3]  = 1'b1;
      run_next   = RUN_IDLE;
      prev_next  = P_NONE;
      start_next = 12'd0;
      pos_next   = 12'd0;
    end
  end

  // Pack the valid candidates in order
  always_comb begin
    scan_out = '0;
    n        = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        if (n < 3'd3) scan_out.tok[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
    scan_out.count = n[1:0];
  end

  // State update on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      run       <= RUN_IDLE;
      prev_kind <= P_NONE;
      start_pos <= 12'd0;
      byte_pos  <= 12'd0;
    end else if (advance) begin
      run       <= run_next;
      prev_kind <= prev_next;
      start_pos <= start_next;
      byte_pos  <= pos_next;
    end
  end

`ifndef SYNTHESIS
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    run.len <= LEN_CAP)
    else $error("token length above cap");

  a_pos_cap: assert property (@(posedge clk) disable iff (rst)
    byte_pos <= POS_CAP)
    else $error("byte position above cap");

  a_eot_reset: assert property (@(posedge clk) disable iff (rst)
    (advance && end_of_text) |=> (run.mode == M_IDLE && byte_pos == 12'd0 &&
                                  prev_kind == P_NONE))
    else $error("lexer state not cleared after end of text");
`endif

endmodule

`default_nettype wire

// File: design/c_style_expression_lexer_top.sv
// Top level of the C-style expression lexer: byte input channel, token output
// channel and a three-entry token buffer. Depends on cexl_pkg and cexl_scan.
// A token is written into the buffer when its byte is accepted and is shown on the
// output in the next cycle. Throughput: one byte per cycle while each byte yields at
// most one token and token_ready is high; extra tokens hold off input until drained.
// Reset: synchronous rst clears the lexer state and empties the token buffer.
`default_nettype none

module c_style_expression_lexer_top #(
  parameter int MAX_TOKEN_LENGTH = cexl_pkg::MAX_TOKEN_LENGTH,
  parameter int MAX_TEXT_LENGTH  = cexl_pkg::MAX_TEXT_LENGTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  logic [7:0]  character,
  input  logic        end_of_text,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [2:0]  token_kind,
  output logic [11:0] token_start,
  output logic [7:0]  token_length,
  output logic        length_clipped,
  output logic        last_item
);

  cexl_pkg::scan_out_t  scan_out;
  cexl_pkg::tok_t [2:0] slots;
  cexl_pkg::tok_t       head_tok;
  logic [1:0]           head;
  logic [1:0]           cnt;
  logic                 in_fire;
  logic                 out_fire;

  // Handshakes: take a byte once the buffer is empty or draining its last word
  assign text_ready  = (cnt == 2'd0) || ((cnt == 2'd1) && token_ready);
  assign token_valid = (cnt != 2'd0);
  assign in_fire     = text_valid && text_ready;
  assign out_fire    = token_valid && token_ready;

  cexl_scan #(
    .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
    .MAX_TEXT_LENGTH  (MAX_TEXT_LENGTH)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .advance     (in_fire),
    .character   (character),
    .end_of_text (end_of_text),
    .scan_out    (scan_out)
  );

  // Token buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 2'd0;
      cnt  <= 2'd0;
    end else if (in_fire) begin
      head <= 2'd0;
      cnt  <= scan_out.count;
    end else if (out_fire) begin
      head <= head + 2'd1;
      cnt  <= cnt - 2'd1;
    end
  end

  // Token buffer payload
  always_ff @(posedge clk) begin
    if (in_fire) slots <= scan_out.tok;
  end

  // Output word
  assign head_tok       = slots[head];
  assign token_kind     = head_tok.kind;
  assign token_start    = head_tok.start;
  assign token_length   = head_tok.length;
  assign length_clipped = head_tok.clipped;
  assign last_item      = head_tok.last;

`ifndef SYNTHESIS
  a_ready_drain: assert property (@(posedge clk) disable iff (rst)
    text_ready |-> (cnt == 2'd0 || (cnt == 2'd1 && token_ready)))
    else $error("byte taken while tokens still pending");

  a_multi_hold: assert property (@(posedge clk) disable iff (rst)
    (out_fire && cnt > 2'd1) |=> (token_valid && cnt == $past(cnt) - 2'd1))
    else $error("pending token lost");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (token_valid && token_kind == cexl_pkg::KIND_END) |-> last_item)
    else $error("end marker without last flag");
`endif

endmodule

`default_nettype wire
